@@ rtl/pfc_pkg.sv @@
// ============================================================================
// pfc_pkg: shared types, constants and helpers of the Playfair stream cipher
// Holds the request codes, the controller/datapath command and status
// structs, and small square-geometry functions for the 5x5 grid.
// ============================================================================
package pfc_pkg;

  // Grid and alphabet geometry
  localparam int unsigned SqSide   = 5;
  localparam int unsigned SqCells  = SqSide * SqSide;
  localparam int unsigned AlphaLen = 26;

  // Letter codes (A = 0)
  localparam logic [4:0] CodeJ = 5'd9;
  localparam logic [4:0] CodeX = 5'd23;

  // ASCII bounds
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;
  localparam logic [7:0] CharSpace = 8'h20;

  // Request codes carried by an input item
  typedef enum logic [1:0] {
    FUNC_KEY    = 2'd0,
    FUNC_FINISH = 2'd1,
    FUNC_MSG    = 2'd2,
    FUNC_END    = 2'd3
  } func_e;

  // Source of an output character
  typedef enum logic [1:0] {
    OSEL_A    = 2'd0,
    OSEL_B    = 2'd1,
    OSEL_CHAR = 2'd2
  } osel_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic  in_ready;
    logic  key_add;
    logic  walk_clr;
    logic  walk_add;
    logic  set_finished;
    logic  hold_set;
    logic  hold_clr;
    logic  pos_rd;
    logic  sq_rd;
    logic  out_load;
    osel_e out_sel;
    logic  out_status;
    logic  out_last;
  } pfc_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic  in_accept;
    func_e func;
    logic  is_letter;
    logic  is_skip;
    logic  same_held;
    logic  held_valid;
    logic  key_finished;
    logic  walk_last;
    logic  out_free;
  } pfc_sts_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CharUpA) && (c <= CharUpZ)) || ((c >= CharLoA) && (c <= CharLoZ));
  endfunction

  function automatic logic [4:0] alpha_code(input logic [7:0] c);
    logic [7:0] d;
    d = (c >= CharLoA) ? (c - CharLoA) : (c - CharUpA);
    return d[4:0];
  endfunction

  // Row of a cell, by compare chain (cell / 5)
  function automatic logic [2:0] cell_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  // Cell number from row and column (row * 5 + col)
  function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
    logic [4:0] r5;
    r5 = {2'b00, r};
    return (r5 << 2) + r5 + {2'b00, c};
  endfunction

  function automatic logic [2:0] cell_col(input logic [4:0] p);
    logic [4:0] d;
    d = p - cell_index(cell_row(p), 3'd0);
    return d[2:0];
  endfunction

  // Move one place along a row or column, wrapping at the edge
  function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic dec);
    logic [2:0] n;
    if (dec) n = (v == 3'd0) ? 3'(SqSide - 1) : (v - 3'd1);
    else     n = (v == 3'(SqSide - 1)) ? 3'd0 : (v + 3'd1);
    return n;
  endfunction

endpackage

@@ rtl/pfc_intf.sv @@
// ============================================================================
// pfc_intf: valid/ready channel interfaces of the Playfair stream cipher
// Request channel, result channel and configuration write channel.
// ============================================================================

// Request item: function code and character
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_in;
  modport source (output valid, output func, output char_in, input ready);
  modport sink   (input valid, input func, input char_in, output ready);
endinterface

// Result item: character, status and last-of-item flag
interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       status;
  logic       last;
  modport source (output valid, output out_char, output status, output last, input ready);
  modport sink   (input valid, input out_char, input status, input last, output ready);
endinterface

// Configuration write: mode bit
interface pfc_cfg_if;
  logic valid;
  logic ready;
  logic decrypt_mode;
  modport source (output valid, output decrypt_mode, input ready);
  modport sink   (input valid, input decrypt_mode, output ready);
endinterface

@@ rtl/playfair_cipher_stream.sv @@
// ============================================================================
// playfair_cipher_stream: streaming Playfair cipher over a 5x5 square
// Builds the square from key items, then turns message items into digraphs
// and ciphers them by the row, column and rectangle rules.
// ============================================================================
// Usage:
//   in_i   : request items {func, char_in}. Key characters first, then a
//            finish item, then message characters and an end-of-message item.
//   out_o  : result items {out_char, status, last}; last marks the final
//            result that one request item causes (up to three per item).
//   cfg_i  : decrypt_mode write, always ready; write only while idle.
// Sequence: a key character is added to the square; an invalid key
// character gives an error result; a message letter may be held; a
// digraph reads the letter position memory, then the square memory, through
// their registered read ports and emits two results in turn; a flushed symbol
// follows its digraph. The first finish, explicit or implied by the first
// message or end item, walks the alphabet once.
// Reset clears the key, the held letter and the mode; the square is rebuilt
// from the next key items. A stalled receiver holds the result in the output
// register and the sequencer waits; the next request is taken as soon as the
// last result of the current one is in that register.
// ============================================================================
module playfair_cipher_stream
  import pfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pfc_in_if.sink     in_i,
  pfc_out_if.source  out_o,
  pfc_cfg_if.sink    cfg_i
);

  pfc_cmd_t cmd;
  pfc_sts_t sts;

  // sequencer
  pfc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // tables and cipher logic
  pfc_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i)
  );

endmodule

@@ rtl/pfc_ctrl.sv @@
// ============================================================================
// pfc_ctrl: sequencing state machine of the Playfair stream cipher
// Dispatches each item, runs the key-finish walk, orders the table reads
// of a digraph and emits up to three results through the output register.
// ============================================================================
module pfc_ctrl
  import pfc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pfc_sts_t sts_i,
  output pfc_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_WALK     = 4'd2;
  localparam logic [3:0] S_MSG      = 4'd3;
  localparam logic [3:0] S_POS      = 4'd4;
  localparam logic [3:0] S_EMIT_A   = 4'd5;
  localparam logic [3:0] S_EMIT_B   = 4'd6;
  localparam logic [3:0] S_EMIT_SYM = 4'd7;
  localparam logic [3:0] S_EMIT_ERR = 4'd8;

  logic [3:0] state_q, state_d;
  logic       sym_after;

  // a message symbol follows its flushed pair
  assign sym_after = (sts_i.func == FUNC_MSG) && !sts_i.is_letter;

  // next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_accept) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts_i.func)
          FUNC_KEY: begin
            if (sts_i.key_finished) begin
              state_d = S_IDLE;
            end else if (!sts_i.is_letter) begin
              state_d = S_EMIT_ERR;
            end else begin
              cmd_o.key_add = 1'b1;
              state_d       = S_IDLE;
            end
          end
          FUNC_FINISH: begin
            if (sts_i.key_finished) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.walk_clr = 1'b1;
              state_d        = S_WALK;
            end
          end
          FUNC_MSG, FUNC_END: begin
            if (sts_i.key_finished) begin
              state_d = S_MSG;
            end else begin
              cmd_o.walk_clr = 1'b1;
              state_d        = S_WALK;
            end
          end
        endcase
      end
      // append the unused letters, one per cycle
      S_WALK: begin
        cmd_o.walk_add = 1'b1;
        if (sts_i.walk_last) begin
          cmd_o.set_finished = 1'b1;
          state_d = (sts_i.func == FUNC_FINISH) ? S_IDLE : S_MSG;
        end
      end
      // digraph building
      S_MSG: begin
        if (sts_i.func == FUNC_MSG) begin
          if (sts_i.is_skip) begin
            state_d = S_IDLE;
          end else if (sts_i.is_letter) begin
            if (!sts_i.held_valid) begin
              cmd_o.hold_set = 1'b1;
              state_d        = S_IDLE;
            end else begin
              cmd_o.pos_rd   = 1'b1;
              cmd_o.hold_clr = !sts_i.same_held;
              state_d        = S_POS;
            end
          end else if (sts_i.held_valid) begin
            cmd_o.pos_rd   = 1'b1;
            cmd_o.hold_clr = 1'b1;
            state_d        = S_POS;
          end else begin
            state_d = S_EMIT_SYM;
          end
        end else if (sts_i.held_valid) begin
          cmd_o.pos_rd   = 1'b1;
          cmd_o.hold_clr = 1'b1;
          state_d        = S_POS;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_POS: begin
        cmd_o.sq_rd = 1'b1;
        state_d     = S_EMIT_A;
      end
      S_EMIT_A: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_A;
          state_d        = S_EMIT_B;
        end
      end
      S_EMIT_B: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_B;
          cmd_o.out_last = !sym_after;
          state_d        = sym_after ? S_EMIT_SYM : S_IDLE;
        end
      end
      S_EMIT_SYM: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_CHAR;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_EMIT_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_sel    = OSEL_CHAR;
          cmd_o.out_status = 1'b1;
          cmd_o.out_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/pfc_datapath.sv @@
// ============================================================================
// pfc_datapath: tables, held letter and digraph logic of the Playfair cipher
// Square and letter-position memories, fill state, item capture, the
// row/column/rectangle rules and the output register.
// ============================================================================
module pfc_datapath
  import pfc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfc_cmd_t        cmd_i,
  output pfc_sts_t        sts_o,
  pfc_in_if.sink          in_i,
  pfc_out_if.source       out_o,
  pfc_cfg_if.sink         cfg_i
);

  // captured item
  func_e      func_q;
  logic [7:0] char_q;
  logic [4:0] code_q;
  logic       letter_q;

  // key state
  logic [AlphaLen-1:0] present_q;
  logic [4:0]          fill_q;
  logic                finished_q;
  logic [4:0]          walk_q;
  logic                decrypt_q;

  // held letter
  logic       held_valid_q;
  logic [4:0] held_q;

  // memories and their registered read data
  logic [4:0] sq_mem  [SqCells];
  logic [4:0] pos_mem [AlphaLen];
  logic [4:0] pos_a_q, pos_b_q;
  logic [4:0] sq_a_q, sq_b_q;

  // output register
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_status_q;
  logic       out_last_q;

  logic       accept;
  logic [4:0] add_code;
  logic       add_ok;
  logic [4:0] pair_b;
  logic [2:0] ra, ca, rb, cb;
  logic [4:0] na, nb;
  logic [7:0] load_char;

  assign in_i.ready  = cmd_i.in_ready;
  assign accept      = in_i.valid && cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;

  // status to controller
  assign sts_o.in_accept    = accept;
  assign sts_o.func         = func_q;
  assign sts_o.is_letter    = letter_q;
  assign sts_o.is_skip      = (char_q == CharSpace) || (letter_q && (code_q == CodeJ));
  assign sts_o.same_held    = (code_q == held_q);
  assign sts_o.held_valid   = held_valid_q;
  assign sts_o.key_finished = finished_q;
  assign sts_o.walk_last    = (walk_q == 5'(AlphaLen - 1));
  assign sts_o.out_free     = !out_valid_q || out_o.ready;

  // letter insertion into the square, from a key item or the finish walk
  assign add_code = cmd_i.walk_add ? walk_q : code_q;
  assign add_ok   = (cmd_i.key_add || cmd_i.walk_add) && (add_code != CodeJ) &&
                    !present_q[add_code] && (fill_q < 5'(SqCells));

  // partner of the held letter: the new letter, else padding X
  assign pair_b = ((func_q == FUNC_MSG) && letter_q && (code_q != held_q)) ? code_q : CodeX;

  // row / column / rectangle rules on the looked-up cells
  always_comb begin
    ra = cell_row(pos_a_q);
    ca = cell_col(pos_a_q);
    rb = cell_row(pos_b_q);
    cb = cell_col(pos_b_q);
    if (ra == rb) begin
      na = cell_index(ra, wrap_step(ca, decrypt_q));
      nb = cell_index(rb, wrap_step(cb, decrypt_q));
    end else if (ca == cb) begin
      na = cell_index(wrap_step(ra, decrypt_q), ca);
      nb = cell_index(wrap_step(rb, decrypt_q), cb);
    end else begin
      na = cell_index(ra, cb);
      nb = cell_index(rb, ca);
    end
  end

  // output character select
  always_comb begin
    unique case (cmd_i.out_sel)
      OSEL_A:  load_char = CharUpA + {3'b000, sq_a_q};
      OSEL_B:  load_char = CharUpA + {3'b000, sq_b_q};
      default: load_char = char_q;
    endcase
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_e'(in_i.func);
      char_q   <= in_i.char_in;
      code_q   <= alpha_code(in_i.char_in);
      letter_q <= is_alpha(in_i.char_in);
    end
  end

  // memories: one write port, two registered read ports each
  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      sq_mem[fill_q]    <= add_code;
      pos_mem[add_code] <= fill_q;
    end
    if (cmd_i.pos_rd) begin
      pos_a_q <= pos_mem[held_q];
      pos_b_q <= pos_mem[pair_b];
    end
    if (cmd_i.sq_rd) begin
      sq_a_q <= sq_mem[na];
      sq_b_q <= sq_mem[nb];
    end
  end

  // key, held-letter and mode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      fill_q       <= '0;
      finished_q   <= 1'b0;
      walk_q       <= '0;
      decrypt_q    <= 1'b0;
      held_valid_q <= 1'b0;
      held_q       <= '0;
    end else begin
      if (cfg_i.valid) decrypt_q <= cfg_i.decrypt_mode;
      if (add_ok) begin
        present_q[add_code] <= 1'b1;
        fill_q              <= fill_q + 5'd1;
      end
      if (cmd_i.walk_clr)          walk_q <= '0;
      else if (cmd_i.walk_add)     walk_q <= walk_q + 5'd1;
      if (cmd_i.set_finished)      finished_q <= 1'b1;
      if (cmd_i.hold_set) begin
        held_valid_q <= 1'b1;
        held_q       <= code_q;
      end else if (cmd_i.hold_clr) begin
        held_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_char_q   <= load_char;
      out_status_q <= cmd_i.out_status;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.status   = out_status_q;
  assign out_o.last     = out_last_q;

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 5'(SqCells))
    else $error("square fill count beyond grid");

  a_finish_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> (fill_q == 5'(SqCells)))
    else $error("key finished with square not full");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_o.ready))
    else $error("output register overwritten while stalled");

  a_held_not_j: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (held_q != CodeJ))
    else $error("held letter is J");

endmodule

@@ tb/sv/tb_playfair_cipher_stream.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_playfair_cipher_stream: self-checking bench of the Playfair stream cipher
// Builds one key square after reset and streams message items through it in
// encrypt and decrypt mode. A predictor inside the bench works out every
// result item, and the results are checked field by field in order. The run
// mixes random idling on both channels with a long receiver hold-off and a
// sender pause.
// ============================================================================
module tb_playfair_cipher_stream
  import pfc_pkg::*;
();

  localparam int SettleCycles = 48;    // covers the alphabet walk after a finish
  localparam int HoldCycles   = 200;   // receiver hold-off length
  localparam int StallLimit   = 4000;  // cycles without any accepted item
  localparam logic ModeEnc    = 1'b0;
  localparam logic ModeDec    = 1'b1;
  localparam logic StsOk      = 1'b0;
  localparam logic StsBadKey  = 1'b1;

  typedef struct packed {
    func_e      fn;
    logic [7:0] ch;
  } cipher_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       st;
    logic       lst;
  } cipher_out_t;

  logic clk_i;
  logic rst_ni;

  pfc_in_if  req_ch ();
  pfc_out_if res_ch ();
  pfc_cfg_if cfg_ch ();

  playfair_cipher_stream dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // Stimulus and scoreboard state
  cipher_req_t req_q [$];
  cipher_out_t cipher_exp_q [$];
  cipher_req_t nxt_req;
  cipher_out_t want;
  int          unaccepted = 0;
  int          err_cnt = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_cnt = 0;

  // Predictor copy of the block state
  logic [4:0]  cell_letter [SqCells] = '{default: '0};
  logic [4:0]  letter_cell [AlphaLen] = '{default: '0};
  logic [25:0] present = '0;
  int          fill_cnt = 0;
  bit          key_done = 1'b0;
  bit          held_v = 1'b0;
  logic [4:0]  held = '0;
  logic        mode_dec = ModeEnc;
  cipher_out_t step_res [3];
  int          step_n;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------
  function automatic int letter_code(input logic [7:0] ch);
    if (ch >= CharUpA && ch <= CharUpZ) return int'(ch - CharUpA);
    if (ch >= CharLoA && ch <= CharLoZ) return int'(ch - CharLoA);
    return -1;
  endfunction

  function automatic void add_letter(input int code);
    if (code < 0 || code >= AlphaLen || code == int'(CodeJ)) return;
    if (present[code]) return;
    if (fill_cnt >= SqCells) return;
    cell_letter[fill_cnt] = code[4:0];
    letter_cell[code]     = 5'(fill_cnt);
    present[code]         = 1'b1;
    fill_cnt++;
  endfunction

  // Append the unused letters once; a message or end item forces this too
  function automatic void complete_square();
    if (key_done) return;
    for (int c = 0; c < AlphaLen; c++) add_letter(c);
    key_done = 1'b1;
  endfunction

  // Row, column and rectangle rules; decrypt moves one cell back
  function automatic void add_digraph(input logic [4:0] a, input logic [4:0] b);
    int pa, pb, ra, ca, rb, cb, stp, na, nb;
    pa  = int'(letter_cell[a]);
    pb  = int'(letter_cell[b]);
    ra  = pa / 5;
    ca  = pa % 5;
    rb  = pb / 5;
    cb  = pb % 5;
    stp = (mode_dec == ModeDec) ? 4 : 1;
    if (ra == rb) begin
      na = ra * 5 + (ca + stp) % 5;
      nb = rb * 5 + (cb + stp) % 5;
    end else if (ca == cb) begin
      na = ((ra + stp) % 5) * 5 + ca;
      nb = ((rb + stp) % 5) * 5 + cb;
    end else begin
      na = ra * 5 + cb;
      nb = rb * 5 + ca;
    end
    step_res[step_n]     = cipher_out_t'{8'(CharUpA + cell_letter[na]), StsOk, 1'b0};
    step_res[step_n + 1] = cipher_out_t'{8'(CharUpA + cell_letter[nb]), StsOk, 1'b0};
    step_n += 2;
  endfunction

  function automatic void predict_item(input func_e fn, input logic [7:0] ch);
    int code;
    code   = letter_code(ch);
    step_n = 0;
    case (fn)
      FUNC_KEY: begin
        if (!key_done) begin
          if (code < 0) begin
            step_res[0] = cipher_out_t'{ch, StsBadKey, 1'b0};
            step_n = 1;
          end else begin
            add_letter(code);
          end
        end
      end
      FUNC_FINISH: complete_square();
      FUNC_MSG: begin
        complete_square();
        if (ch != CharSpace && code != int'(CodeJ)) begin
          if (code >= 0) begin
            if (!held_v) begin
              held   = code[4:0];
              held_v = 1'b1;
            end else if (code == int'(held)) begin
              // doubled letter: pad with X, the new letter stays held
              add_digraph(held, CodeX);
            end else begin
              add_digraph(held, code[4:0]);
              held_v = 1'b0;
            end
          end else begin
            // symbol: flush a held letter, then pass the byte through
            if (held_v) begin
              add_digraph(held, CodeX);
              held_v = 1'b0;
            end
            step_res[step_n] = cipher_out_t'{ch, StsOk, 1'b0};
            step_n++;
          end
        end
      end
      default: begin
        complete_square();
        if (held_v) begin
          add_digraph(held, CodeX);
          held_v = 1'b0;
        end
      end
    endcase
    if (step_n > 0) step_res[step_n - 1].lst = 1'b1;
    for (int i = 0; i < step_n; i++) cipher_exp_q.insert(cipher_exp_q.size(), step_res[i]);
  endfunction

  // ------------------------------------------------------------------------
  // Request driver: offers queued items, predicts at acceptance
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_item(func_e'(req_ch.func), req_ch.char_in);
        unaccepted--;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_q.size() != 0 && int'($urandom_range(0, 99)) >= snd_idle_pct) begin
          nxt_req = req_q.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.func    <= nxt_req.fn;
          req_ch.char_in <= nxt_req.ch;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result monitor: compares each item with the oldest expectation
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (cipher_exp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, actual char %h status %b last %b",
                   $time, res_ch.out_char, res_ch.status, res_ch.last);
        end else begin
          want = cipher_exp_q.pop_front();
          if (res_ch.out_char !== want.ch) begin
            err_cnt++;
            $display("%0t: out_char expected %h actual %h", $time, want.ch, res_ch.out_char);
          end
          if (res_ch.status !== want.st) begin
            err_cnt++;
            $display("%0t: status expected %b actual %b", $time, want.st, res_ch.status);
          end
          if (res_ch.last !== want.lst) begin
            err_cnt++;
            $display("%0t: last expected %b actual %b", $time, want.lst, res_ch.last);
          end
        end
      end
      // long hold-off on request, otherwise random backpressure
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= (int'($urandom_range(0, 99)) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
      end
      if (stall_cnt >= StallLimit) begin
        $display("%0t: timeout, %0d results still expected", $time, cipher_exp_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  task automatic queue_req(input func_e fn, input logic [7:0] ch);
    req_q.insert(req_q.size(), cipher_req_t'{fn, ch});
    unaccepted++;
  endtask

  task automatic wait_drained();
    while (unaccepted != 0 || cipher_exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk_i);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.decrypt_mode <= m;
    do @(posedge clk_i); while (!cfg_ch.ready);
    mode_dec = m;
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly digraph-forming letters, with doubles, real X, symbols and ends
  task automatic queue_random_msgs(input int count);
    int         made, r;
    logic [7:0] ch, prev;
    made = 0;
    prev = CharUpA;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        ch   = 8'(CharUpA + $urandom_range(0, 25));
        ch   = $urandom_range(0, 1) ? (ch | 8'h20) : ch;
        prev = ch;
        queue_req(FUNC_MSG, ch);
      end else if (r < 65) begin
        queue_req(FUNC_MSG, $urandom_range(0, 1) ? (prev | 8'h20) : (prev & 8'hDF));
      end else if (r < 72) begin
        queue_req(FUNC_MSG, $urandom_range(0, 1) ? "X" : "x");
      end else if (r < 80) begin
        queue_req(FUNC_MSG, 8'($urandom_range(0, 255)));
      end else if (r < 84) begin
        case ($urandom_range(0, 2))
          0:       queue_req(FUNC_MSG, CharSpace);
          1:       queue_req(FUNC_MSG, "J");
          default: queue_req(FUNC_MSG, "j");
        endcase
      end else if (r < 92) begin
        queue_req(FUNC_END, 8'($urandom_range(0, 255)));
      end else if (r < 96) begin
        queue_req(FUNC_MSG, 8'($urandom_range(0, 64)));
      end else begin
        // ignored once the key is done; not counted
        queue_req($urandom_range(0, 1) ? FUNC_KEY : FUNC_FINISH, 8'($urandom_range(0, 255)));
        made--;
      end
      made++;
    end
    queue_req(FUNC_END, 8'h00);
  endtask

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------
  initial begin
    int fin_variant;
    rst_ni              = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.func         = FUNC_KEY;
    req_ch.char_in      = 8'h00;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.decrypt_mode = ModeEnc;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Encrypt, sender idles less than receiver
    snd_idle_pct = 22;
    rcv_idle_pct = 48;
    write_mode(ModeEnc);

    // key: byte extremes, case folding, J, repeats
    queue_req(FUNC_KEY, 8'h00);
    queue_req(FUNC_KEY, "P");
    queue_req(FUNC_KEY, "l");
    queue_req(FUNC_KEY, "J");
    queue_req(FUNC_KEY, "a");
    queue_req(FUNC_KEY, "A");
    queue_req(FUNC_KEY, "y");
    queue_req(FUNC_KEY, 8'hFF);
    queue_req(FUNC_KEY, "{");
    // first finish: explicit, implied by a message, or implied by an end
    fin_variant = $urandom_range(0, 2);
    if (fin_variant == 0) queue_req(FUNC_FINISH, 8'h00);
    else if (fin_variant == 2) queue_req(FUNC_END, 8'h00);
    queue_req(FUNC_MSG, "a");
    queue_req(FUNC_MSG, "Z");
    queue_req(FUNC_FINISH, 8'h00);   // repeated finish
    queue_req(FUNC_KEY, "Q");        // key after finish
    queue_req(FUNC_MSG, "e");        // doubled letter, then a real X
    queue_req(FUNC_MSG, "E");
    queue_req(FUNC_MSG, "X");
    queue_req(FUNC_MSG, "x");        // XX, then a symbol flush
    queue_req(FUNC_MSG, "X");
    queue_req(FUNC_MSG, "!");
    queue_req(FUNC_MSG, "J");
    queue_req(FUNC_MSG, CharSpace);
    queue_req(FUNC_MSG, 8'h80);
    queue_req(FUNC_MSG, "f");
    queue_req(FUNC_END, 8'hFF);      // flush a held letter
    queue_req(FUNC_END, 8'h00);      // nothing held
    queue_random_msgs(35);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    // Decrypt, idling swapped, long receiver hold-off while items queue up
    snd_idle_pct = 48;
    rcv_idle_pct = 22;
    write_mode(ModeDec);
    hold_req = 1'b1;
    queue_random_msgs(40);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    // Encrypt, no idling; sender pauses until all results are in
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_mode(ModeEnc);
    queue_random_msgs(20);
    wait_drained();
    queue_random_msgs(20);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
